// ===== sv/sha512_pkg.sv =====
// Package for the SHA-512 message hasher: round constants, initial hash value,
// controller-to-datapath command and status types. No dependencies.
package sha512_pkg;

   localparam int WordWidth = 64;
   localparam int BlockWords = 16;
   localparam int StateWords = 8;
   localparam int Rounds = 80;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [1:0] {
      WSRC_DATA = 2'd0,
      WSRC_ZERO = 2'd1,
      WSRC_LEN_HI = 2'd2,
      WSRC_LEN_LO = 2'd3
   } word_src_type;

   typedef struct packed {
      logic         push;
      word_src_type src;
      logic         pad_after;
      logic         pad_only;
      logic         round_start;
      logic         round_step;
      logic         fold;
      logic         reinit;
      logic         len_add;
      logic [3:0]   len_bytes;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] word_count;
      logic       rounds_done;
   } dp_status_type;

   function automatic word_type initial_hash(input logic [2:0] idx);
      word_type r;
      unique case (idx)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         default: r = 64'h5be0cd19137e2179;
      endcase
      return r;
   endfunction

   localparam word_type RoundK [Rounds] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

endpackage

// ===== sv/sha512_datapath.sv =====
// Datapath of the SHA-512 hasher: block word buffer as a sliding schedule window,
// working variables, chaining state and byte length. Uses sha512_pkg.
module sha512_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha512_pkg::dp_cmd_type   cmd,
   input  sha512_pkg::word_type     in_data,
   input  logic [2:0]               out_index,
   output sha512_pkg::dp_status_type status,
   output sha512_pkg::word_type     out_word
);
   import sha512_pkg::*;

   word_type   win_ff [BlockWords];
   word_type   win_in [BlockWords];
   word_type   var_ff [StateWords];
   word_type   var_in [StateWords];
   word_type   chain_ff [StateWords];
   word_type   chain_in [StateWords];
   logic [3:0] count_ff, count_in;
   logic [6:0] round_ff, round_in;
   logic [63:0] len_ff, len_in;
   word_type   push_word, w_now, w_new, s0, s1, big0, big1, ch, maj, t1, t2;
   logic [3:0] nb;
   word_type   mask, padbit;

   function automatic word_type ror(input word_type x, input int s);
      return (x >> s) | (x << (WordWidth - s));
   endfunction

   always_comb begin
      nb = (cmd.len_bytes > 4'd8) ? 4'd8 : cmd.len_bytes;
      mask = ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
      padbit = 64'h8000_0000_0000_0000 >> {nb, 3'b000};
      case (cmd.src)
         WSRC_DATA: push_word = cmd.pad_only ? 64'h8000_0000_0000_0000
                    : cmd.pad_after ? ((in_data & mask) | padbit) : in_data;
         WSRC_ZERO: push_word = '0;
         WSRC_LEN_HI: push_word = {61'd0, len_ff[63:61]};
         default: push_word = {len_ff[60:0], 3'b000};
      endcase
   end

   always_comb begin
      w_now = win_ff[0];
      s0 = ror(win_ff[1], 1) ^ ror(win_ff[1], 8) ^ (win_ff[1] >> 7);
      s1 = ror(win_ff[14], 19) ^ ror(win_ff[14], 61) ^ (win_ff[14] >> 6);
      w_new = win_ff[0] + s0 + win_ff[9] + s1;
      big1 = ror(var_ff[4], 14) ^ ror(var_ff[4], 18) ^ ror(var_ff[4], 41);
      big0 = ror(var_ff[0], 28) ^ ror(var_ff[0], 34) ^ ror(var_ff[0], 39);
      ch = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t1 = var_ff[7] + big1 + ch + RoundK[round_ff] + w_now;
      t2 = big0 + maj;
   end

   always_comb begin
      win_in = win_ff;
      var_in = var_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      round_in = round_ff;
      len_in = len_ff;
      if (cmd.push) begin
         win_in[count_ff] = push_word;
         count_in = count_ff + 4'd1;
      end
      if (cmd.len_add) begin
         len_in = len_ff + {60'd0, nb};
      end
      if (cmd.round_start) begin
         var_in = chain_ff;
         round_in = '0;
      end
      if (cmd.round_step) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[BlockWords - 1] = w_new;
         for (int i = StateWords - 1; i > 0; i--) begin
            var_in[i] = var_ff[i - 1];
         end
         var_in[4] = var_ff[3] + t1;
         var_in[0] = t1 + t2;
         round_in = round_ff + 7'd1;
      end
      if (cmd.fold) begin
         for (int i = 0; i < StateWords; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end
      if (cmd.reinit) begin
         for (int i = 0; i < StateWords; i++) begin
            chain_in[i] = initial_hash(3'(i));
         end
         count_in = '0;
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      var_ff <= var_in;
      round_ff <= round_in;
      if (reset) begin
         for (int i = 0; i < StateWords; i++) begin
            chain_ff[i] <= initial_hash(3'(i));
         end
         count_ff <= '0;
         len_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
         len_ff <= len_in;
      end
   end

   assign status.word_count = count_ff;
   assign status.rounds_done = (round_ff == 7'(Rounds - 1));
   assign out_word = chain_ff[out_index];

endmodule

// ===== sv/sha512_control.sv =====
// Controller of the SHA-512 hasher: input handshake, padding sequence,
// round sequencing and digest output. Uses sha512_pkg.
module sha512_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [3:0]                 req_valid_bytes,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_word_index,
   output logic                       rsp_digest_last,
   input  sha512_pkg::dp_status_type  status,
   output sha512_pkg::dp_cmd_type     cmd
);
   import sha512_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD80, ST_ZERO, ST_LENHI, ST_LENLO, ST_ROUND, ST_FOLD, ST_OUT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;
   logic       take, full;

   assign req_stall = (state_ff != ST_IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = idx_ff;
   assign rsp_digest_last = (idx_ff == 3'd7);

   always_comb begin
      cmd = '0;
      cmd.src = WSRC_DATA;
      state_in = state_ff;
      ret_in = ret_ff;
      idx_in = idx_ff;
      full = (status.word_count == 4'd15);
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.len_add = 1'b1;
               cmd.len_bytes = req_last ? req_valid_bytes : 4'd8;
               if (!req_last) begin
                  cmd.push = 1'b1;
                  ret_in = ST_IDLE;
               end else if (req_valid_bytes == 4'd0) begin
                  cmd.push = 1'b1;
                  cmd.pad_only = 1'b1;
                  ret_in = ST_ZERO;
               end else if (req_valid_bytes >= 4'd8) begin
                  cmd.push = 1'b1;
                  ret_in = ST_PAD80;
               end else begin
                  cmd.push = 1'b1;
                  cmd.pad_after = 1'b1;
                  ret_in = ST_ZERO;
               end
               if (full) begin
                  state_in = ST_ROUND;
                  cmd.round_start = 1'b1;
               end else begin
                  state_in = ret_in;
               end
            end
         end
         ST_PAD80: begin
            cmd.push = 1'b1;
            cmd.pad_only = 1'b1;
            ret_in = ST_ZERO;
            if (full) begin
               state_in = ST_ROUND;
               cmd.round_start = 1'b1;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.word_count == 4'd14) begin
               state_in = ST_LENHI;
            end else begin
               cmd.push = 1'b1;
               cmd.src = WSRC_ZERO;
               if (full) begin
                  ret_in = ST_ZERO;
                  state_in = ST_ROUND;
                  cmd.round_start = 1'b1;
               end
            end
         end
         ST_LENHI: begin
            cmd.push = 1'b1;
            cmd.src = WSRC_LEN_HI;
            state_in = ST_LENLO;
         end
         ST_LENLO: begin
            cmd.push = 1'b1;
            cmd.src = WSRC_LEN_LO;
            cmd.round_start = 1'b1;
            ret_in = ST_OUT;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.rounds_done) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            idx_in = '0;
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reinit = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== sv/sha512_message_hasher_unit.sv =====
// SHA-512 message hasher top level: joins controller and datapath.
// Operation: a beat not completing a block is taken without a stall; a full block adds
// 80 rounds, one per cycle, then a fold. A last beat then pads (adding a block where
// the length does not fit) and gives eight digest beats, one per unstalled cycle.
// Input is stalled while a block is hashed, since there is a single round unit.
// Reset: synchronous; loads the initial hash value and clears the length and count.
module sha512_message_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);
   import sha512_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sha512_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_valid_bytes, .req_last,
      .rsp_valid, .rsp_stall, .rsp_word_index, .rsp_digest_last,
      .status, .cmd
   );

   sha512_datapath u_datapath (
      .clock, .reset, .cmd, .in_data(req_data), .out_index(rsp_word_index),
      .status, .out_word(rsp_digest_word)
   );

endmodule

// ===== sv/sha512_checker.sv =====
// Port-level checker for the SHA-512 hasher, bound to the top level.
// Depends only on the top level's ports.
module sha512_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_word_index,
   input logic       rsp_digest_last
);
   a_last_at_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_word_index == 3'd7)))
      else $error("digest_last does not match word index");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_digest_last |=> rsp_valid &&
      rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest beats not consecutive");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while digest pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_index))
      else $error("stalled digest beat changed");
endmodule

bind sha512_message_hasher_unit sha512_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_word_index, .rsp_digest_last
);
